// ----- design/ctwt_pkg.sv -----
`default_nettype none

package ctwt_pkg;

  localparam int MAX_ENTRIES_DEF = 256;

  localparam logic [15:0] TRACE_DECAY_RST   = 16'd58982;
  localparam logic [15:0] LEARNING_RATE_RST = 16'd8192;
  localparam logic [8:0]  ENTRIES_RST       = 9'd256;

  localparam logic [1:0] CFG_TRACE_DECAY    = 2'd0;
  localparam logic [1:0] CFG_LEARNING_RATE  = 2'd1;
  localparam logic [1:0] CFG_ENTRIES_IN_USE = 2'd2;

  typedef enum logic [2:0] {
    OP_STEP      = 3'd0,
    OP_UPDATE    = 3'd1,
    OP_GET       = 3'd2,
    OP_CLR_TRACE = 3'd3,
    OP_CLR_WEIGHT = 3'd4
  } op_t;

  typedef struct packed {
    logic [15:0]        trace;
    logic signed [31:0] weight;
  } entry_t;

  typedef struct packed {
    op_t  op;
    logic walk;
    logic bump;
  } alu_ctl_t;

endpackage

`default_nettype wire

// ----- design/ctwt_cell.sv -----
`default_nettype none

module ctwt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  ctwt_pkg::entry_t  d,
  output ctwt_pkg::entry_t  q
);

  ctwt_pkg::entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- design/ctwt_alu.sv -----
`default_nettype none

module ctwt_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift,
  input  ctwt_pkg::alu_ctl_t ctl,
  input  ctwt_pkg::entry_t   head,
  input  logic [15:0]        decay,
  input  logic [31:0]        rb,
  input  logic               neg,
  output ctwt_pkg::entry_t   tail
);

  ctwt_pkg::entry_t   ent_r;
  ctwt_pkg::alu_ctl_t ctl_r;
  logic [47:0]        prod_r;
  logic [47:0]        prod_nxt;
  logic [31:0]        mul_a;

  logic [31:0]        dec_rnd;
  logic [15:0]        t_base;
  logic [16:0]        bump_sum;
  logic [15:0]        t_new;
  logic [47:0]        upd_rnd;
  logic [33:0]        d_ext;
  logic signed [33:0] w_sum;
  logic signed [31:0] w_new;

  assign mul_a    = (ctl.op == ctwt_pkg::OP_UPDATE) ? rb : {16'd0, decay};
  assign prod_nxt = 48'(mul_a) * 48'(head.trace);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{op: ctwt_pkg::OP_STEP, walk: 1'b0, bump: 1'b0};
    end else if (shift) begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ent_r  <= head;
      prod_r <= prod_nxt;
    end
  end

  // decay with round half up, then bump by one minus lambda
  assign dec_rnd  = prod_r[31:0] + 32'h0000_8000;
  assign t_base   = ctl_r.walk ? dec_rnd[31:16] : ent_r.trace;
  assign bump_sum = {1'b0, t_base} + (17'h1_0000 - {1'b0, decay});
  always_comb begin
    t_new = t_base;
    if (ctl_r.bump) begin
      t_new = bump_sum[16] ? 16'hFFFF : bump_sum[15:0];
    end
  end

  // round to nearest, ties away from zero, on the magnitude
  assign upd_rnd = prod_r + 48'h20_0000;
  assign d_ext   = {8'd0, upd_rnd[47:22]};
  assign w_sum   = {{2{ent_r.weight[31]}}, ent_r.weight} + (neg ? -d_ext : d_ext);
  always_comb begin
    w_new = w_sum[31:0];
    if (w_sum[33:31] != 3'b000 && w_sum[33:31] != 3'b111) begin
      w_new = w_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    tail = ent_r;
    case (ctl_r.op)
      ctwt_pkg::OP_STEP: begin
        tail.trace = t_new;
      end
      ctwt_pkg::OP_UPDATE: begin
        if (ctl_r.walk) tail.weight = w_new;
      end
      ctwt_pkg::OP_CLR_TRACE: begin
        if (ctl_r.walk) tail.trace = '0;
      end
      ctwt_pkg::OP_CLR_WEIGHT: begin
        if (ctl_r.walk) tail.weight = '0;
      end
      default: begin
        tail = ent_r;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/critic_trace_weight_table.sv -----
// Eligibility traces and critic weights for MaxEntries states, held in a ring of cells
// that rotates through one shared multiply stage. Every op, get included, rotates the
// whole ring once: a prep state forms r * beta, the ring then rotates through the
// arithmetic stage, and the block returns to idle, where the next item is accepted;
// a new item is taken only once the rotation has ended. A get
// result sits in an output register and is shown when the rotation ends; a further
// get does not finish until that result is taken.
// The user must write configuration only while the block is idle; it is not enforced.
`default_nettype none

module critic_trace_weight_table #(
  parameter int MaxEntries = ctwt_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_state_index,
  input  logic        in_state_present,
  input  logic signed [15:0] in_reinforcement,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_weight_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = $clog2(MaxEntries + 1);
  localparam int WW = (CW > 9) ? CW : 9;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_WALK, S_HOLD} state_t;

  state_t             state_r;
  ctwt_pkg::op_t      op_r;
  logic [7:0]         idx_r;
  logic               present_r;
  logic               neg_r;
  logic [15:0]        rm_r;
  logic [31:0]        rb_r;
  logic [CW-1:0]      cnt_r;
  logic signed [31:0] get_val_r;
  logic               out_valid_r;
  logic signed [31:0] out_weight_r;
  logic [15:0]        decay_r;
  logic [15:0]        rate_r;
  logic [8:0]         entries_r;

  logic               shift;
  logic               last;
  logic               hit;
  logic               out_free;
  logic               out_load;
  ctwt_pkg::alu_ctl_t ctl;
  ctwt_pkg::entry_t   chain_q [MaxEntries];
  ctwt_pkg::entry_t   alu_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r   <= ctwt_pkg::TRACE_DECAY_RST;
      rate_r    <= ctwt_pkg::LEARNING_RATE_RST;
      entries_r <= ctwt_pkg::ENTRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctwt_pkg::CFG_TRACE_DECAY:    decay_r   <= cfg_wdata;
        ctwt_pkg::CFG_LEARNING_RATE:  rate_r    <= cfg_wdata;
        ctwt_pkg::CFG_ENTRIES_IN_USE: entries_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign shift    = (state_r == S_WALK);
  assign last     = (cnt_r == CW'(MaxEntries));
  assign hit      = !last && (WW'(idx_r) == WW'(cnt_r));
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (op_r == ctwt_pkg::OP_GET) && out_free
                    && ((state_r == S_WALK && last) || (state_r == S_HOLD));

  always_comb begin
    ctl.op   = op_r;
    ctl.walk = !last && (WW'(cnt_r) < WW'(entries_r));
    ctl.bump = hit && present_r && (op_r == ctwt_pkg::OP_STEP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= ctwt_pkg::OP_STEP;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_weight_r <= get_val_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= ctwt_pkg::op_t'(in_op);
            idx_r     <= in_state_index;
            present_r <= in_state_present;
            neg_r     <= in_reinforcement[15];
            rm_r      <= in_reinforcement[15] ? 16'(-in_reinforcement)
                                              : 16'(in_reinforcement);
            state_r   <= S_PREP;
          end
        end
        S_PREP: begin
          rb_r      <= 32'(rm_r) * 32'(rate_r);
          cnt_r     <= '0;
          get_val_r <= '0;
          state_r   <= S_WALK;
        end
        S_WALK: begin
          if (hit) get_val_r <= chain_q[0].weight;
          if (last) begin
            cnt_r <= '0;
            if (op_r == ctwt_pkg::OP_GET && !out_free) begin
              state_r <= S_HOLD;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_weight_value = out_weight_r;

  for (genvar k = 0; k < MaxEntries; k++) begin : g_cell
    if (k == MaxEntries - 1) begin : g_tail
      ctwt_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d     (alu_out),
        .q     (chain_q[k])
      );
    end else begin : g_body
      ctwt_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d     (chain_q[k+1]),
        .q     (chain_q[k])
      );
    end
  end

  ctwt_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (shift),
    .ctl   (ctl),
    .head  (chain_q[0]),
    .decay (decay_r),
    .rb    (rb_r),
    .neg   (neg_r),
    .tail  (alu_out)
  );

  a_ring_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && last) |=> (state_r != S_WALK))
    else $error("ring rotation overran");

  a_aligned_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cnt_r == '0))
    else $error("ring not aligned while idle");

  a_result_from_get: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (op_r == ctwt_pkg::OP_GET))
    else $error("result raised by an op other than get");

  a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_valid_r && !out_ready) |=> (state_r == S_HOLD))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- tb/sv/critic_trace_weight_table_checker.sv -----
`default_nettype none

module critic_trace_weight_table_checker
  import ctwt_pkg::*;
#(
  parameter int MaxEntries = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [7:0]         in_state_index,
  input  logic               in_state_present,
  input  logic signed [15:0] in_reinforcement,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_weight_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0]        lambda_q;
  logic [15:0]        beta_q;
  logic [8:0]         entry_cnt;
  logic [15:0]        trace_mem [MaxEntries];
  logic signed [31:0] weight_mem [MaxEntries];
  logic signed [31:0] expected_weights [$];
  int                 mismatches = 0;

  function automatic int walk_len();
    return (entry_cnt > MaxEntries) ? MaxEntries : int'(entry_cnt);
  endfunction

  task automatic decay_and_bump(input logic [7:0] idx, input logic present);
    logic [32:0] prod;
    logic [16:0] sum;
    for (int i = 0; i < walk_len(); i++) begin
      prod = 33'(trace_mem[i]) * 33'(lambda_q) + 33'd32768;
      trace_mem[i] = prod[31:16];
    end
    if (present && idx < MaxEntries) begin
      sum = 17'(trace_mem[idx]) + (17'd65536 - 17'(lambda_q));
      trace_mem[idx] = sum[16] ? 16'hFFFF : sum[15:0];
    end
  endtask

  task automatic reinforce(input logic signed [15:0] r);
    logic               neg;
    logic [63:0]        mag;
    logic [63:0]        prod;
    logic [63:0]        delta;
    logic signed [63:0] w;
    neg = r < 0;
    mag = 64'(neg ? -int'(r) : int'(r));
    for (int i = 0; i < walk_len(); i++) begin
      prod = mag * 64'(beta_q) * 64'(trace_mem[i]);
      delta = (prod + 64'(1 << 21)) >> 22;
      w = weight_mem[i];
      w = neg ? w - signed'(delta) : w + signed'(delta);
      if (w > 64'sd2147483647) w = 64'sd2147483647;
      if (w < -64'sd2147483648) w = -64'sd2147483648;
      weight_mem[i] = w[31:0];
    end
  endtask

  task automatic flag(input string what, input logic signed [31:0] want,
                      input logic signed [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lambda_q = TRACE_DECAY_RST;
      beta_q = LEARNING_RATE_RST;
      entry_cnt = ENTRIES_RST;
      for (int i = 0; i < MaxEntries; i++) begin
        trace_mem[i] = '0;
        weight_mem[i] = '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRACE_DECAY:    lambda_q = cfg_wdata;
          CFG_LEARNING_RATE:  beta_q = cfg_wdata;
          CFG_ENTRIES_IN_USE: entry_cnt = cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_op)
          OP_STEP:       decay_and_bump(in_state_index, in_state_present);
          OP_UPDATE:     reinforce(in_reinforcement);
          OP_GET:        expected_weights.push_back(
                           (in_state_index < MaxEntries) ? weight_mem[in_state_index] : '0);
          OP_CLR_TRACE:  for (int i = 0; i < walk_len(); i++) trace_mem[i] = '0;
          OP_CLR_WEIGHT: for (int i = 0; i < walk_len(); i++) weight_mem[i] = '0;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_weights.size() == 0)
          flag("unexpected weight item", '0, out_weight_value);
        else if (out_weight_value !== expected_weights[0])
          flag("weight mismatch", expected_weights[0], out_weight_value);
        if (expected_weights.size() != 0)
          void'(expected_weights.pop_front());
      end
    end
    pending <= expected_weights.size();
    fail_count <= mismatches;
  end

endmodule

`default_nettype wire

// ----- tb/sv/critic_trace_weight_table_tb.sv -----
`default_nettype none

module critic_trace_weight_table_tb;
  import ctwt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 4_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_op = OP_STEP;
  logic [7:0]         in_state_index = '0;
  logic               in_state_present = 1'b0;
  logic signed [15:0] in_reinforcement = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_weight_value;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_TRACE_DECAY;
  logic [15:0]        cfg_wdata = '0;

  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 22;
  int                 recv_idle_pct = 74;
  int unsigned        cycle_cnt = 0;

  critic_trace_weight_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_state_index   (in_state_index),
    .in_state_present (in_state_present),
    .in_reinforcement (in_reinforcement),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_weight_value (out_weight_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  critic_trace_weight_table_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_state_index   (in_state_index),
    .in_state_present (in_state_present),
    .in_reinforcement (in_reinforcement),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_weight_value (out_weight_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [7:0] idx,
                           input logic present, input logic [15:0] r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_state_index <= idx;
    in_state_present <= present;
    in_reinforcement <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_item();
    int          pick;
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [15:0] r;
    pick = $urandom_range(99);
    if (pick < 36) op = OP_STEP;
    else if (pick < 60) op = OP_UPDATE;
    else if (pick < 88) op = OP_GET;
    else if (pick < 92) op = OP_CLR_TRACE;
    else if (pick < 95) op = OP_CLR_WEIGHT;
    else op = 3'($urandom_range(7, int'(OP_CLR_WEIGHT) + 1));
    // keep most items on a few hot entries so traces and weights build up
    idx = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom);
    case ($urandom_range(3))
      0:       r = 16'h7FFF;
      1:       r = 16'h8000;
      default: r = 16'($urandom);
    endcase
    send_item(op, idx, $urandom_range(3) != 0, r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // hold off until any walk still in flight has finished
    repeat (MAX_ENTRIES_DEF + 16) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] lambda, input logic [15:0] beta,
                            input logic [8:0] entries);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TRACE_DECAY;
    cfg_wdata <= lambda;
    @(posedge clk);
    cfg_index <= CFG_LEARNING_RATE;
    cfg_wdata <= beta;
    @(posedge clk);
    cfg_index <= CFG_ENTRIES_IN_USE;
    cfg_wdata <= 16'(entries);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_GET, 8'd0, 1'b0, 16'h0000);
    send_item(OP_STEP, 8'd0, 1'b1, 16'h0000);
    send_item(OP_STEP, 8'd255, 1'b1, 16'hFFFF);
    send_item(OP_STEP, 8'd0, 1'b0, 16'h0000);
    send_item(OP_UPDATE, 8'd0, 1'b0, 16'h7FFF);
    send_item(OP_GET, 8'd0, 1'b0, 16'h0000);
    send_item(OP_GET, 8'd255, 1'b1, 16'h0000);
    send_item(OP_UPDATE, 8'd255, 1'b1, 16'h8000);
    send_item(OP_GET, 8'd128, 1'b0, 16'h0000);
    send_item(OP_UPDATE, 8'd0, 1'b0, 16'h0000);
    send_item(OP_GET, 8'd0, 1'b0, 16'h0000);
    send_item(OP_CLR_TRACE, 8'd0, 1'b0, 16'h0000);
    send_item(OP_UPDATE, 8'd0, 1'b0, 16'h0001);
    send_item(OP_GET, 8'd255, 1'b0, 16'h0000);
    send_item(OP_CLR_WEIGHT, 8'hFF, 1'b1, 16'hFFFF);
    send_item(OP_GET, 8'd255, 1'b0, 16'h0000);
    send_item(3'(int'(OP_CLR_WEIGHT) + 1), 8'd0, 1'b1, 16'h7FFF);
    send_item(3'(int'(OP_CLR_WEIGHT) + 2), 8'd0, 1'b1, 16'h8000);
    send_item(3'(int'(OP_CLR_WEIGHT) + 3), 8'hFF, 1'b1, 16'hFFFF);
    settle();

    // bump an entry that lies beyond the walked range
    set_config(16'd0, 16'hFFFF, 9'd1);
    send_item(OP_STEP, 8'd200, 1'b1, 16'h0000);
    send_item(OP_STEP, 8'd0, 1'b1, 16'h0000);
    send_item(OP_UPDATE, 8'd0, 1'b0, 16'h7FFF);
    send_item(OP_GET, 8'd200, 1'b0, 16'h0000);
    send_item(OP_GET, 8'd0, 1'b0, 16'h0000);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0:       set_config(16'hFFFF, 16'hFFFF, 9'h1FF);
        1:       set_config(16'd0, 16'hFFFF, 9'd256);
        2:       set_config(16'($urandom), 16'($urandom), 9'($urandom));
        3:       set_config(16'd1, 16'd0, 9'd0);
        4:       set_config(16'($urandom), 16'($urandom), 9'd2);
        default: set_config(TRACE_DECAY_RST, LEARNING_RATE_RST, ENTRIES_RST);
      endcase
      if (ph < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 74;
      end else if (ph < 4) begin
        send_idle_pct = 74;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (300) random_item();
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/ctwt_pkg.sv
design/ctwt_cell.sv
design/ctwt_alu.sv
design/critic_trace_weight_table.sv
tb/sv/critic_trace_weight_table_checker.sv
tb/sv/critic_trace_weight_table_tb.sv
